FILE: rtl/cit_pkg.sv
// ----------------------------------------------------------------------------
// cit_pkg: shared types and constants for the tour editor
// Opcodes, status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package cit_pkg;

  // Node numbers arrive as 6-bit fields, so the node count is fixed here.
  localparam int unsigned MaxNodes    = 64;
  localparam int unsigned DefDistBits = 16;
  localparam int unsigned CostBits    = 22;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_APPEND = 3'd2,
    OP_DROP   = 3'd3,
    OP_ADD    = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISSING  = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SLOT,
    S_FIND,
    S_FIND_C,
    S_SHL,
    S_SHL_W,
    S_SCAN_T,
    S_SCAN_A,
    S_SCAN_B,
    S_SCAN_D0,
    S_SCAN_D1,
    S_SCAN_C,
    S_SHR,
    S_SHR_W,
    S_PUT,
    S_SUM_T,
    S_SUM_D,
    S_SUM_A,
    S_DONE
  } state_e;

endpackage

FILE: rtl/cheapest_insertion_tour_edit.sv
// ----------------------------------------------------------------------------
// cheapest_insertion_tour_edit: tour editor with cheapest insertion
// Keeps a distance table and an ordered tour; every word returns route cost.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | opcode, nodes, distance, slot
//  out     | output    | out_valid_o/out_stall_i | cost, length, position, status
//
// One word at a time; each word is accepted, decoded and finished in the done
// state. The route sum walks the entries after the edit (tour read, distance
// read, accumulate). Drop searches the entries for the node and moves the later
// ones down; add scans the gaps, moves the entries after the best gap up and
// places the node. The block has one tour memory port and one distance port.
// Reset clears the tour count, the state and the output valid; both memories are undefined until written.
// A finished word waits in the output register; the next input word is taken
// meanwhile, and the block holds in its done state until that word leaves.
// ----------------------------------------------------------------------------
module cheapest_insertion_tour_edit
  import cit_pkg::*;
#(
  parameter int unsigned DIST_BITS = DefDistBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          opcode_i,
  input  logic [5:0]          from_node_i,
  input  logic [5:0]          to_node_i,
  input  logic [15:0]         distance_i,
  input  logic [5:0]          node_i,
  input  logic [6:0]          slot_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CostBits-1:0] route_cost_o,
  output logic [6:0]          tour_length_o,
  output logic [6:0]          insert_position_o,
  output logic [5:0]          slot_node_o,
  output logic [1:0]          status_o
);

  localparam int unsigned NB   = $clog2(MaxNodes);
  localparam int unsigned Cap  = MaxNodes + 1;
  localparam int unsigned TB   = $clog2(Cap);       // tour index bits
  localparam int unsigned CB   = $clog2(Cap + 1);   // tour count bits
  localparam int unsigned DB   = DIST_BITS + 2;     // signed detour bits
  localparam int unsigned AB   = DIST_BITS + CB;    // accumulator bits
  localparam int unsigned Dep  = MaxNodes * MaxNodes;
  localparam logic [CB-1:0] CapCnt  = CB'(Cap);
  localparam logic [AB-1:0] CostCap = AB'(2**CostBits - 1);

  // Memories
  logic [DIST_BITS-1:0] dist_mem [Dep];
  logic [NB-1:0]        tour_mem [Cap];

  state_e state_q, state_d;

  logic [2:0]  op_q;
  logic [NB-1:0] fr_q, to_q, n_q;
  logic [DIST_BITS-1:0] dv_q;
  logic [6:0]  slot_q;
  logic [CB-1:0] cnt_q, cnt_d;
  logic [CB-1:0] k_q, k_d;
  logic [TB-1:0] pos_q, pos_d;
  logic [1:0]  stat_q, stat_d;
  logic [NB-1:0] snode_q, snode_d;
  logic [NB-1:0] a_q, a_d, b_q, b_d;
  logic signed [DB-1:0] c_q, c_d, best_q, best_d;
  logic signed [DB-1:0] det;
  logic        have_q, have_d;
  logic [AB-1:0] acc_q, acc_d;

  // memory control
  logic          t_we, t_re;
  logic [TB-1:0] t_wa, t_ra;
  logic [NB-1:0] t_wd, t_rd_q;
  logic          d_we, d_re;
  logic [2*NB-1:0] d_ra;
  logic [DIST_BITS-1:0] d_rd_q;

  // handshakes and output register
  logic take_in, out_load;
  logic out_valid_q;
  logic [CostBits-1:0] out_cost_q;
  logic [6:0]  out_len_q, out_pos_q;
  logic [5:0]  out_snode_q;
  logic [1:0]  out_stat_q;

  assign take_in  = (state_q == S_IDLE) && in_valid_i;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign route_cost_o      = out_cost_q;
  assign tour_length_o     = out_len_q;
  assign insert_position_o = out_pos_q;
  assign slot_node_o       = out_snode_q;
  assign status_o          = out_stat_q;

  // Detour of the current gap once the edge distance lands.
  assign det = c_q - $signed(DB'(d_rd_q));

  always_ff @(posedge clk_i) begin
    if (d_we) dist_mem[{fr_q, to_q}] <= dv_q;
    if (d_re) d_rd_q <= dist_mem[d_ra];
    if (t_we) tour_mem[t_wa] <= t_wd;
    if (t_re) t_rd_q <= tour_mem[t_ra];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (op_q)
          OP_APPEND: state_d = (cnt_q >= CapCnt) ? S_SUM_T : S_PUT;
          OP_DROP:   state_d = S_FIND;
          OP_ADD: begin
            if (cnt_q >= CapCnt) state_d = S_SUM_T;
            else if (cnt_q < CB'(2)) state_d = S_SHR;
            else state_d = S_SCAN_T;
          end
          OP_READ:   state_d = ({1'b0, slot_q} >= 8'(cnt_q)) ? S_SUM_T : S_SLOT;
          default:   state_d = S_SUM_T;
        endcase
      end
      S_SLOT:    state_d = S_SUM_T;
      S_FIND:    state_d = (k_q == cnt_q) ? S_SUM_T : S_FIND_C;
      S_FIND_C:  state_d = (t_rd_q == n_q) ? S_SHL : S_FIND;
      S_SHL:     state_d = (k_q + CB'(1) < cnt_q) ? S_SHL_W : S_SUM_T;
      S_SHL_W:   state_d = S_SHL;
      S_SCAN_T:  state_d = (k_q + CB'(1) < cnt_q) ? S_SCAN_A : S_SHR;
      S_SCAN_A:  state_d = S_SCAN_B;
      S_SCAN_B:  state_d = S_SCAN_D0;
      S_SCAN_D0: state_d = S_SCAN_D1;
      S_SCAN_D1: state_d = S_SCAN_C;
      S_SCAN_C:  state_d = S_SCAN_T;
      S_SHR:     state_d = (k_q > CB'(pos_q)) ? S_SHR_W : S_PUT;
      S_SHR_W:   state_d = S_SHR;
      S_PUT:     state_d = S_SUM_T;
      S_SUM_T:   state_d = (k_q < cnt_q) ? S_SUM_D : S_DONE;
      S_SUM_D:   state_d = S_SUM_A;
      S_SUM_A:   state_d = S_SUM_T;
      S_DONE:    if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_d = cnt_q; k_d = k_q; pos_d = pos_q; stat_d = stat_q;
    snode_d = snode_q; a_d = a_q; b_d = b_q;
    c_d = c_q; best_d = best_q; have_d = have_q; acc_d = acc_q;
    t_we = 1'b0; t_wa = '0; t_wd = n_q; t_re = 1'b0; t_ra = '0;
    d_we = 1'b0; d_re = 1'b0; d_ra = {a_q, n_q};
    case (state_q)
      S_DECODE: begin
        k_d = '0; pos_d = '0; stat_d = ST_OK; snode_d = '0; have_d = 1'b0;
        best_d = '0;
        case (op_q)
          OP_WRITE:  d_we = 1'b1;
          OP_CLEAR:  cnt_d = '0;
          OP_APPEND: if (cnt_q >= CapCnt) stat_d = ST_FULL;
          OP_ADD: begin
            // short tour: shift everything up and place at the front
            if (cnt_q >= CapCnt) stat_d = ST_FULL;
            else if (cnt_q < CB'(2)) k_d = cnt_q;
          end
          OP_READ: begin
            if ({1'b0, slot_q} >= 8'(cnt_q)) stat_d = ST_RANGE;
            else begin
              t_re = 1'b1; t_ra = TB'(slot_q);
            end
          end
          default: ;
        endcase
      end
      S_SLOT:   snode_d = t_rd_q;
      S_FIND: begin
        if (k_q == cnt_q) stat_d = ST_MISSING;
        else begin
          t_re = 1'b1; t_ra = TB'(k_q);
        end
      end
      S_FIND_C: if (t_rd_q != n_q) k_d = k_q + CB'(1);
      S_SHL: begin
        // read entry k+1, write it down to k in the next cycle
        if (k_q + CB'(1) < cnt_q) begin
          t_re = 1'b1; t_ra = TB'(k_q + CB'(1));
        end else cnt_d = cnt_q - CB'(1);
      end
      S_SHL_W: begin
        t_we = 1'b1; t_wa = TB'(k_q); t_wd = t_rd_q; k_d = k_q + CB'(1);
      end
      S_SCAN_T: begin
        // k_q counts gaps; after the last one start the shift from the top
        if (k_q + CB'(1) < cnt_q) begin
          t_re = 1'b1; t_ra = TB'(k_q);
        end else k_d = cnt_q;
      end
      S_SCAN_A: begin
        a_d = t_rd_q; t_re = 1'b1; t_ra = TB'(k_q + CB'(1));
      end
      S_SCAN_B: begin
        b_d = t_rd_q; d_re = 1'b1; d_ra = {a_q, n_q};
      end
      S_SCAN_D0: begin
        c_d = DB'(d_rd_q); d_re = 1'b1; d_ra = {n_q, b_q};
      end
      S_SCAN_D1: begin
        c_d = c_q + $signed(DB'(d_rd_q)); d_re = 1'b1; d_ra = {a_q, b_q};
      end
      S_SCAN_C: begin
        // keep the first gap with the smallest detour
        if (!have_q || det < best_q) begin
          best_d = det; have_d = 1'b1; pos_d = TB'(k_q + CB'(1));
        end
        k_d = k_q + CB'(1);
      end
      S_SHR: begin
        // k_q walks down from count; move entry k-1 to k
        if (k_q > CB'(pos_q)) begin
          t_re = 1'b1; t_ra = TB'(k_q - CB'(1));
        end
      end
      S_SHR_W: begin
        t_we = 1'b1; t_wa = TB'(k_q); t_wd = t_rd_q; k_d = k_q - CB'(1);
      end
      S_PUT: begin
        // append lands at the tail and reports position zero
        t_we = 1'b1; t_wa = (op_q == OP_APPEND) ? TB'(cnt_q) : pos_q; t_wd = n_q;
        cnt_d = cnt_q + CB'(1);
      end
      S_SUM_T: begin
        if (k_q < cnt_q) begin
          t_re = 1'b1; t_ra = TB'(k_q);
        end
      end
      S_SUM_D: begin
        // t_rd_q holds tour[k]; previous node in a_q
        b_d = t_rd_q;
        d_re = (k_q != '0); d_ra = {a_q, t_rd_q};
      end
      S_SUM_A: begin
        if (k_q != '0) acc_d = acc_q + AB'(d_rd_q);
        a_d = b_q; k_d = k_q + CB'(1);
      end
      default: ;
    endcase

    // Start the route sum from the head of the tour.
    if (state_d == S_SUM_T && state_q != S_SUM_A) begin
      k_d = '0; acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      op_q <= opcode_i;
      fr_q <= NB'(from_node_i);
      to_q <= NB'(to_node_i);
      n_q  <= NB'(node_i);
      dv_q <= DIST_BITS'(distance_i);
      slot_q <= slot_i;
    end
    k_q <= k_d; pos_q <= pos_d; stat_q <= stat_d; snode_q <= snode_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; best_q <= best_d; have_q <= have_d;
    acc_q <= acc_d;
    if (out_load) begin
      out_cost_q  <= (acc_q > CostCap) ? '1 : CostBits'(acc_q);
      out_len_q   <= 7'(cnt_q);
      out_pos_q   <= 7'(pos_q);
      out_snode_q <= 6'(snode_q);
      out_stat_q  <= stat_q;
    end
  end

endmodule

FILE: rtl/cit_checker.sv
// ----------------------------------------------------------------------------
// cit_checker: port-level checks for the tour editor
// Watches handshakes and result fields.
// ----------------------------------------------------------------------------
module cit_checker
  import cit_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] tour_length_o,
  input logic [1:0] status_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("accept not held off");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("word dropped");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tour_length_o <= 7'd65) else $error("length range");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> tour_length_o == 7'd65)
    else $error("full status without full tour");

endmodule

bind cheapest_insertion_tour_edit cit_checker u_cit_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .tour_length_o, .status_o
);

FILE: bench/tour_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tour_checker: predicts and checks tour editor results
// Watches both channels, keeps its own distance table and tour, and compares
// every output word with the oldest predicted one.
// ----------------------------------------------------------------------------
module tour_checker
  import cit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  opcode_i,
  input  logic [5:0]  from_node_i,
  input  logic [5:0]  to_node_i,
  input  logic [15:0] distance_i,
  input  logic [5:0]  node_i,
  input  logic [6:0]  slot_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [21:0] route_cost_i,
  input  logic [6:0]  tour_length_i,
  input  logic [6:0]  insert_position_i,
  input  logic [5:0]  slot_node_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [21:0] cost;
    logic [6:0]  len;
    logic [6:0]  pos;
    logic [5:0]  snode;
    logic [1:0]  status;
  } tour_reply_t;

  logic [15:0] dist_tab [64*64];
  logic [5:0]  tour [65];
  int          tour_len;
  tour_reply_t reply_q [$];

  function automatic longint edge_dist(logic [5:0] a, logic [5:0] b);
    return longint'(dist_tab[{a, b}]);
  endfunction

  function automatic logic [21:0] tour_cost();
    longint sum;
    sum = 0;
    for (int k = 0; k + 1 < tour_len; k++) sum += edge_dist(tour[k], tour[k+1]);
    return (sum > 64'h3fffff) ? 22'h3fffff : sum[21:0];
  endfunction

  task automatic apply_word();
    tour_reply_t r;
    int          k, best_pos;
    longint      best, c;
    r = '0;
    case (opcode_i)
      OP_WRITE: dist_tab[{from_node_i, to_node_i}] = distance_i;
      OP_CLEAR: tour_len = 0;
      OP_APPEND: begin
        if (tour_len >= 65) r.status = ST_FULL;
        else begin
          tour[tour_len] = node_i;
          tour_len++;
        end
      end
      OP_DROP: begin
        for (k = 0; k < tour_len; k++) if (tour[k] == node_i) break;
        if (k == tour_len) r.status = ST_MISSING;
        else begin
          for (; k + 1 < tour_len; k++) tour[k] = tour[k+1];
          tour_len--;
        end
      end
      OP_ADD: begin
        if (tour_len >= 65) r.status = ST_FULL;
        else begin
          best_pos = 0;
          best = 0;
          for (k = 0; k + 1 < tour_len; k++) begin
            c = edge_dist(tour[k], node_i) + edge_dist(node_i, tour[k+1])
                - edge_dist(tour[k], tour[k+1]);
            if (k == 0 || c < best) begin
              best = c;
              best_pos = k + 1;
            end
          end
          // shift the tail up by one and drop the node in
          for (k = tour_len; k > best_pos; k--) tour[k] = tour[k-1];
          tour[best_pos] = node_i;
          tour_len++;
          r.pos = best_pos[6:0];
        end
      end
      OP_READ: begin
        if (slot_i >= tour_len) r.status = ST_RANGE;
        else r.snode = tour[slot_i];
      end
      default: ;
    endcase
    r.cost = tour_cost();
    r.len  = tour_len[6:0];
    reply_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tour_reply_t want;
    int          errs;
    errs = 0;
    if (!rst_ni) begin
      tour_len = 0;
      reply_q.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          $error("output word with no prediction waiting");
          errs++;
        end else begin
          want = reply_q.pop_front();
          if (route_cost_i !== want.cost) begin
            $error("route_cost expected %0d got %0d", want.cost, route_cost_i);
            errs++;
          end
          if (tour_length_i !== want.len) begin
            $error("tour_length expected %0d got %0d", want.len, tour_length_i);
            errs++;
          end
          if (insert_position_i !== want.pos) begin
            $error("insert_position expected %0d got %0d", want.pos, insert_position_i);
            errs++;
          end
          if (slot_node_i !== want.snode) begin
            $error("slot_node expected %0d got %0d", want.snode, slot_node_i);
            errs++;
          end
          if (status_i !== want.status) begin
            $error("status expected %0d got %0d", want.status, status_i);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_word();
      fail_count_o <= fail_count_o + errs;
    end
    pending_o = reply_q.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top of the tour editor bench
// Writes the distances among a small node set before any use, builds tours
// by append and cheapest insertion, drops and reads slots, and fills the tour
// to its limit. A checker beside the block predicts every word; this module
// drives words, stalls the output at random and prints the verdict.
// ----------------------------------------------------------------------------
module tb
  import cit_pkg::*;
;

  localparam int LimitCycles = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode = OP_CLEAR;
  logic [5:0]  from_node = '0;
  logic [5:0]  to_node = '0;
  logic [15:0] distance = '0;
  logic [5:0]  node = '0;
  logic [6:0]  slot = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [21:0] route_cost;
  logic [6:0]  tour_length;
  logic [6:0]  insert_position;
  logic [5:0]  slot_node;
  logic [1:0]  status;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  // rough tour length, used to bias clears and slot picks
  int          shadow_len = 0;

  always #2 clk_i = ~clk_i;

  cheapest_insertion_tour_edit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .from_node_i(from_node), .to_node_i(to_node),
    .distance_i(distance), .node_i(node), .slot_i(slot),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .route_cost_o(route_cost), .tour_length_o(tour_length),
    .insert_position_o(insert_position), .slot_node_o(slot_node),
    .status_o(status)
  );

  tour_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .from_node_i(from_node), .to_node_i(to_node),
    .distance_i(distance), .node_i(node), .slot_i(slot),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .route_cost_i(route_cost), .tour_length_i(tour_length),
    .insert_position_i(insert_position), .slot_node_i(slot_node),
    .status_i(status),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stall the output at random; the rate changes with the phase.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Tour nodes come from this set only; all its pairs are written first.
  function automatic logic [5:0] set_node(int j);
    return (j == 7) ? 6'd63 : 6'(j);
  endfunction

  function automatic logic [5:0] rand_node();
    return set_node($urandom_range(7));
  endfunction

  // Hold one word until accepted, with random idle cycles ahead of it.
  task automatic send_word(op_e op, logic [5:0] fr, logic [5:0] to_n,
                           logic [15:0] dv, logic [5:0] nd, logic [6:0] sl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    from_node <= fr;
    to_node   <= to_n;
    distance  <= dv;
    node      <= nd;
    slot      <= sl;
    do @(posedge clk_i); while (in_stall);
    case (op)
      OP_CLEAR: shadow_len = 0;
      OP_APPEND, OP_ADD: if (shadow_len < 65) shadow_len++;
      default: ;
    endcase
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) send_word(OP_WRITE, 6'($urandom), 6'($urandom), 16'($urandom), '0, '0);
    else if (pick < 14) send_word(OP_CLEAR, '0, '0, '0, '0, '0);
    else if (pick < 34) send_word(OP_APPEND, '0, '0, '0, rand_node(), '0);
    else if (pick < 50) send_word(OP_DROP, '0, '0, '0, 6'($urandom), '0);
    else if (pick < 78) send_word(OP_ADD, '0, '0, '0, rand_node(), '0);
    else if (pick < 96) send_word(OP_READ, '0, '0, '0, '0, 7'($urandom_range(shadow_len + 2)));
    else send_word(op_e'(3'($urandom_range(7, 6))), 6'($urandom), 6'($urandom),
                   16'($urandom), 6'($urandom), 7'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Write every pair of the node set so no add or sum reads an empty
    // entry; include the zero and full-scale distances.
    for (int i = 0; i < 64; i++)
      send_word(OP_WRITE, set_node(i / 8), set_node(i % 8),
                (i == 0) ? 16'h0000 : (i == 63) ? 16'hffff : 16'($urandom), '0, '0);

    // Directed: short tours, add on empty and single entry, drop missing,
    // duplicates, slot range, unused opcodes.
    send_word(OP_ADD, '0, '0, '0, 6'd63, '0);
    send_word(OP_ADD, '0, '0, '0, 6'd0, '0);
    send_word(OP_READ, '0, '0, '0, '0, 7'd0);
    send_word(OP_READ, '0, '0, '0, '0, 7'd2);
    send_word(OP_READ, '0, '0, '0, '0, 7'd127);
    send_word(OP_APPEND, '0, '0, '0, 6'd5, '0);
    send_word(OP_APPEND, '0, '0, '0, 6'd5, '0);
    send_word(OP_ADD, '0, '0, '0, 6'd3, '0);
    send_word(OP_DROP, '0, '0, '0, 6'd5, '0);
    send_word(OP_DROP, '0, '0, '0, 6'd42, '0);
    send_word(op_e'(3'd6), 6'd63, 6'd63, 16'hffff, 6'd63, 7'd127);
    send_word(op_e'(3'd7), '0, '0, '0, '0, '0);
    send_word(OP_WRITE, 6'd63, 6'd0, 16'hffff, '0, '0);
    send_word(OP_CLEAR, '0, '0, '0, '0, '0);
    send_word(OP_DROP, '0, '0, '0, 6'd0, '0);
    // Fill to the limit, then overflow by append and by add.
    for (int i = 0; i < 65; i++) send_word(OP_ADD, '0, '0, '0, rand_node(), '0);
    send_word(OP_APPEND, '0, '0, '0, 6'd1, '0);
    send_word(OP_ADD, '0, '0, '0, 6'd2, '0);
    send_word(OP_READ, '0, '0, '0, '0, 7'd64);
    send_word(OP_READ, '0, '0, '0, '0, 7'd65);
    send_word(OP_CLEAR, '0, '0, '0, '0, '0);

    // Random phases: receiver idles, then sender idles, then neither.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 7 : 0;
      for (int i = 0; i < 115; i++) begin
        // keep tours short most of the time, clear when they get long
        if (shadow_len > 20 && $urandom_range(3) == 0) send_word(OP_CLEAR, '0, '0, '0, '0, '0);
        else random_word();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
